/* rtl/otlt_pkg.sv */
package otlt_pkg;

	// Default table geometry.
	localparam int ENTRIES_DEF    = 256;
	localparam int COUNT_BITS_DEF = 8;

	// Fixed field widths.
	localparam int ID_W      = 8;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_FRAMES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT     = 1'd1;

	// Decision carried from the check logic to the result register.
	typedef struct packed {
		logic remove;
		logic deactivate;
	} decision_t;

endpackage

/* rtl/otlt_entry_ram.sv */
module otlt_entry_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// One read port with registered data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/otlt_check.sv */
module otlt_check #(
	parameter int COUNT_BITS = otlt_pkg::COUNT_BITS_DEF
) (
	input  logic                          tracked,
	input  logic                          active,
	input  logic                          free_space,
	input  logic [otlt_pkg::CFG_W-1:0]    confirm_frames,
	input  logic [otlt_pkg::CFG_W-1:0]    miss_limit,
	input  logic [2*(COUNT_BITS+1)-1:0]   entry_in,
	output logic [2*(COUNT_BITS+1)-1:0]   entry_out,
	output otlt_pkg::decision_t           decision
);

	import otlt_pkg::*;

	localparam int CNT_MAX = (1 << COUNT_BITS) - 1;

	logic                  conf_p, miss_p;
	logic [COUNT_BITS-1:0] conf_l, miss_l;
	logic                  conf_p_n, miss_p_n;
	logic [COUNT_BITS-1:0] conf_l_n, miss_l_n;
	logic                  rem, deact;

	// A loaded limit saturates at the largest count.
	function automatic logic [COUNT_BITS-1:0] clamp_count(input logic [CFG_W-1:0] v);
		if (32'(v) > CNT_MAX) begin
			return CNT_MAX[COUNT_BITS-1:0];
		end
		return COUNT_BITS'(v);
	endfunction

	assign {conf_p, conf_l, miss_p, miss_l} = entry_in;

	// Confirmation check, then the missed-detection check unless removal was ordered.
	always_comb begin
		conf_p_n = conf_p;
		conf_l_n = conf_l;
		miss_p_n = miss_p;
		miss_l_n = miss_l;
		rem      = 1'b0;
		deact    = 1'b0;
		if (active && !free_space) begin
			if (confirm_frames != '0) begin
				if (!conf_p) begin
					conf_p_n = 1'b1;
					conf_l_n = clamp_count(confirm_frames);
				end else if (conf_l != '0) begin
					if (tracked) begin
						conf_l_n = conf_l - 1'b1;
					end else begin
						rem = 1'b1;
					end
				end
			end
			if (!rem && miss_limit != '0) begin
				if (tracked) begin
					miss_p_n = 1'b0;
				end else begin
					miss_p_n = 1'b1;
					miss_l_n = miss_p ? miss_l : clamp_count(miss_limit);
					if (miss_l_n != '0) begin
						miss_l_n = miss_l_n - 1'b1;
					end
					deact = (miss_l_n == '0);
				end
			end
		end
	end

	assign entry_out           = {conf_p_n, conf_l_n, miss_p_n, miss_l_n};
	assign decision.remove     = rem;
	assign decision.deactivate = deact;

endmodule

/* rtl/object_track_lifecycle_table_top.sv */
// Object track lifecycle table: one object check per beat. A taken beat passes the input
// register, loaded with the entry RAM read, and then the result register, which loads once
// the output is free. A new beat is taken every cycle while results drain. The limit is the
// single read-modify-write port pair of the entry RAM; a write that the next beat's read
// misses is forwarded. After reset the block clears the entry RAM, one entry per cycle, and
// holds in_stall high until the pass ends; configuration writes are taken at any time.
module object_track_lifecycle_table_top #(
	parameter int ENTRIES    = otlt_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = otlt_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [otlt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [otlt_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [otlt_pkg::ID_W-1:0]      object_id,
	input  logic                           tracked,
	input  logic                           active,
	input  logic                           free_space,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           remove,
	output logic                           deactivate
);

	import otlt_pkg::*;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int WORD_W = 2 * (COUNT_BITS + 1);

	logic [CFG_W-1:0]  confirm_frames_q, miss_limit_q;
	logic              clr_active_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic              s1_valid_q;
	logic [IDX_W-1:0]  idx_s1;
	logic              tracked_s1, active_s1, free_space_s1;
	logic              fwd_s1;
	logic [WORD_W-1:0] fwd_data_s1;
	logic              out_valid_q, remove_q, deactivate_q;

	logic              accept, advance, out_free;
	logic [IDX_W-1:0]  idx_in;
	logic [WORD_W-1:0] ram_rd, entry_cur, entry_new, wr_data;
	logic [IDX_W-1:0]  wr_addr;
	logic              wr_en;
	decision_t         decision;

	// Object id modulo ENTRIES by conditional subtraction, one step per id bit.
	function automatic logic [IDX_W-1:0] id_to_index(input logic [ID_W-1:0] id);
		logic [31:0] r;
		r = 32'(id);
		for (int k = ID_W - 1; k >= 0; k--) begin
			if (r >= (32'(ENTRIES) << k)) begin
				r = r - (32'(ENTRIES) << k);
			end
		end
		return IDX_W'(r);
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_frames_q <= '0;
			miss_limit_q     <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CONFIRM_FRAMES: confirm_frames_q <= cfg_data;
				REG_MISS_LIMIT:     miss_limit_q     <= cfg_data;
				default:            ;
			endcase
		end
	end

	// Clearing pass over the entry RAM after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clr_active_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == IDX_W'(ENTRIES - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// Handshake control.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = s1_valid_q && out_free;
	assign in_stall = clr_active_q || (s1_valid_q && !out_free);
	assign accept   = in_valid && !in_stall;
	assign idx_in   = id_to_index(object_id);

	// Entry RAM write: clearing pass or the updated entry of the advancing beat.
	assign wr_en   = clr_active_q || advance;
	assign wr_addr = clr_active_q ? clr_cnt_q : idx_s1;
	assign wr_data = clr_active_q ? '0 : entry_new;

	otlt_entry_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (accept),
		.rd_addr(idx_in),
		.rd_data(ram_rd)
	);

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Input stage payload, plus forwarding of a write that lands with the read.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1        <= idx_in;
			tracked_s1    <= tracked;
			active_s1     <= active;
			free_space_s1 <= free_space;
			fwd_s1        <= advance && (idx_s1 == idx_in);
			fwd_data_s1   <= entry_new;
		end
	end

	assign entry_cur = fwd_s1 ? fwd_data_s1 : ram_rd;

	otlt_check #(
		.COUNT_BITS(COUNT_BITS)
	) u_check (
		.tracked       (tracked_s1),
		.active        (active_s1),
		.free_space    (free_space_s1),
		.confirm_frames(confirm_frames_q),
		.miss_limit    (miss_limit_q),
		.entry_in      (entry_cur),
		.entry_out     (entry_new),
		.decision      (decision)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			remove_q     <= decision.remove;
			deactivate_q <= decision.deactivate;
		end
	end

	assign out_valid  = out_valid_q;
	assign remove     = remove_q;
	assign deactivate = deactivate_q;

	// Removal and deactivation are never ordered by the same beat.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(remove_q && deactivate_q))
		else $error("remove and deactivate both set");

	// A skipped object yields an all-zero result.
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (!active_s1 || free_space_s1)) |=> (!remove_q && !deactivate_q))
		else $error("skipped object produced an order");

	// The clearing pass runs once after reset.
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_active_q |=> !clr_active_q)
		else $error("clearing pass restarted");

	// An advancing beat always shows up as a result.
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advancing beat lost");

endmodule
